[rtl/core/rfsc_pkg.sv]
package rfsc_pkg;

   // Stack depth (entries of 32 bits; entry 0 is the top).
   localparam int STACK_DEPTH = 4;

   // Depth of the request queue and of the result queue (a power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Working width of the float datapath mantissa and of its exponent.
   localparam int MW = 56;
   localparam int EW = 12;

   localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
   localparam logic [31:0] FLOAT_ZERO = 32'h0000_0000;

   // Request codes as they arrive on the request port.
   localparam logic [2:0] REQ_PUSH  = 3'd0;
   localparam logic [2:0] REQ_POP   = 3'd1;
   localparam logic [2:0] REQ_READ  = 3'd2;
   localparam logic [2:0] REQ_SWAP  = 3'd3;
   localparam logic [2:0] REQ_ARITH = 3'd4;

   typedef enum logic [2:0] {
      CMD_PUSH,
      CMD_POP,
      CMD_READ,
      CMD_SWAP,
      CMD_ARITH,
      CMD_BAD
   } cmd_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      cmd_type     cmd;
      op_type      op;
      logic [31:0] value;
   } item_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] value;
   } rsp_type;

   typedef struct packed {
      logic        start;
      op_type      op;
      logic [31:0] lhs;
      logic [31:0] rhs;
   } fpu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } fpu_rsp_type;

   typedef enum logic [2:0] {
      FPU_IDLE,
      FPU_PRENORM,
      FPU_DIVIDE,
      FPU_NORM,
      FPU_ROUND,
      FPU_DONE
   } fpu_state_type;

   typedef enum logic {
      BK_IDLE,
      BK_WAIT
   } back_state_type;

endpackage

[rtl/core/rpn_float_stack_calculator.sv]
// Channel   Ports                                        Handshake
// request   req_type, req_push_value, req_op_code        push / full
// result    rsp_ok, rsp_result_value                     empty / pop
//
// Push, pop, read, swap and failed or unused requests are handled in the
// executing stage alone. Add, subtract and multiply normalize one bit of
// shift per step before rounding; NaN and infinity operands skip to the result.
// Divide normalizes subnormal operands, forms a 27-bit quotient one bit per
// step and then shifts the result one bit per step; quotients far below the
// normal range need the most shift steps.
// Reset clears the stack to +0.0 and empties both queues.
// A two-entry queue on each side lets requests enter while results wait.
module rpn_float_stack_calculator (
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_push_value,
   input  logic [1:0]  req_op_code,
   input  logic        push,
   output logic        full,
   output logic        rsp_ok,
   output logic [31:0] rsp_result_value,
   output logic        empty,
   input  logic        pop
);

   logic                  fe_valid;
   rfsc_pkg::item_type    fe_item;
   logic                  fe_take;
   rfsc_pkg::fpu_req_type fpu_req;
   rfsc_pkg::fpu_rsp_type fpu_rsp;

   rfsc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .req_op_code    (req_op_code),
      .push           (push),
      .full           (full),
      .fe_valid       (fe_valid),
      .fe_item        (fe_item),
      .fe_take        (fe_take)
   );

   rfsc_fpu u_fpu (
      .clock   (clock),
      .reset   (reset),
      .fpu_req (fpu_req),
      .fpu_rsp (fpu_rsp)
   );

   rfsc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .fe_valid         (fe_valid),
      .fe_item          (fe_item),
      .fe_take          (fe_take),
      .fpu_req          (fpu_req),
      .fpu_rsp          (fpu_rsp),
      .empty            (empty),
      .pop              (pop),
      .rsp_ok           (rsp_ok),
      .rsp_result_value (rsp_result_value)
   );

   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      fe_take |-> fe_valid)
      else $error("request queue read while empty");

   a_start_single: assert property (@(posedge clock) disable iff (reset)
      fpu_req.start |=> !fpu_req.start)
      else $error("float unit started twice in a row");

   a_no_start_on_done: assert property (@(posedge clock) disable iff (reset)
      fpu_rsp.done |-> !fpu_req.start)
      else $error("float unit started while delivering");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("result queue not empty after reset");

endmodule

[rtl/core/rfsc_front.sv]
module rfsc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_type,
   input  logic [31:0]        req_push_value,
   input  logic [1:0]         req_op_code,
   input  logic               push,
   output logic               full,
   output logic               fe_valid,
   output rfsc_pkg::item_type fe_item,
   input  logic               fe_take
);

   rfsc_pkg::item_type                 queue_ff [rfsc_pkg::QUEUE_DEPTH];
   logic [rfsc_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [rfsc_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [rfsc_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;
   rfsc_pkg::item_type                 new_item;
   logic                               wr_en;
   logic                               rd_en;

   always_comb begin
      new_item.value = req_push_value;
      new_item.op    = rfsc_pkg::op_type'(req_op_code);
      case (req_type)
         rfsc_pkg::REQ_PUSH:  new_item.cmd = rfsc_pkg::CMD_PUSH;
         rfsc_pkg::REQ_POP:   new_item.cmd = rfsc_pkg::CMD_POP;
         rfsc_pkg::REQ_READ:  new_item.cmd = rfsc_pkg::CMD_READ;
         rfsc_pkg::REQ_SWAP:  new_item.cmd = rfsc_pkg::CMD_SWAP;
         rfsc_pkg::REQ_ARITH: new_item.cmd = rfsc_pkg::CMD_ARITH;
         default:             new_item.cmd = rfsc_pkg::CMD_BAD;
      endcase
   end

   assign full     = (cnt_ff == rfsc_pkg::QCNT_W'(rfsc_pkg::QUEUE_DEPTH));
   assign fe_valid = (cnt_ff != '0);
   assign fe_item  = queue_ff[rd_ptr_ff];
   assign wr_en    = push && !full;
   assign rd_en    = fe_take && fe_valid;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + rfsc_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + rfsc_pkg::QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + rfsc_pkg::QCNT_W'(1);
      end else if (!wr_en && rd_en) begin
         cnt_in = cnt_ff - rfsc_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[rtl/core/rfsc_fpu.sv]
module rfsc_fpu (
   input  logic                  clock,
   input  logic                  reset,
   input  rfsc_pkg::fpu_req_type fpu_req,
   output rfsc_pkg::fpu_rsp_type fpu_rsp
);

   localparam int MW = rfsc_pkg::MW;
   localparam int EW = rfsc_pkg::EW;
   localparam logic signed [EW-1:0] E_ONE  = EW'(1);
   localparam logic signed [EW-1:0] E_TINY = EW'(-MW);
   localparam logic signed [EW-1:0] E_INF  = EW'(255);

   rfsc_pkg::fpu_state_type state_ff, state_in;
   logic [MW-1:0]           m_ff, m_in;
   logic signed [EW-1:0]    e_ff, e_in;
   logic                    sign_ff, sign_in;
   logic [31:0]             res_ff, res_in;
   logic [23:0]             da_ff, da_in;
   logic [23:0]             db_ff, db_in;
   logic [24:0]             rem_ff, rem_in;
   logic [26:0]             q_ff, q_in;
   logic [4:0]              cnt_ff, cnt_in;

   // Operand decode.
   logic [31:0]          a, b;
   logic [7:0]           a_exp, b_exp, a_ef, b_ef;
   logic [23:0]          a_man, b_man;
   logic signed [EW-1:0] a_e, b_e;
   logic                 a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

   // Add path.
   logic                 b_sign_eff, a_big, x_sign, y_sign, eff_sub, add_sign;
   logic [23:0]          x_man, y_man;
   logic [7:0]           x_ef, y_ef, d8;
   logic [5:0]           d6;
   logic [MW-1:0]        x_al, y_al, add_m;
   logic [2*MW-1:0]      y_wide;

   // Multiply and divide.
   logic [47:0]          prod;
   logic                 q_bit;
   logic [24:0]          rem_sub;

   // Rounding.
   logic [23:0]          r_man;
   logic                 r_guard, r_sticky, r_inc;
   logic [24:0]          r_sum;
   logic [23:0]          r_final;
   logic signed [EW-1:0] r_e;

   always_comb begin
      a      = fpu_req.lhs;
      b      = fpu_req.rhs;
      a_exp  = a[30:23];
      b_exp  = b[30:23];
      a_ef   = (a_exp == 8'd0) ? 8'd1 : a_exp;
      b_ef   = (b_exp == 8'd0) ? 8'd1 : b_exp;
      a_man  = {(a_exp != 8'd0), a[22:0]};
      b_man  = {(b_exp != 8'd0), b[22:0]};
      a_e    = {{(EW-8){1'b0}}, a_ef};
      b_e    = {{(EW-8){1'b0}}, b_ef};
      a_nan  = (a_exp == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (b_exp == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (a_exp == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (b_exp == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);

      // The larger magnitude goes first so that a subtraction never goes negative.
      b_sign_eff = b[31] ^ (fpu_req.op == rfsc_pkg::OP_SUB);
      a_big      = (a[30:0] >= b[30:0]);
      x_sign     = a_big ? a[31] : b_sign_eff;
      y_sign     = a_big ? b_sign_eff : a[31];
      x_man      = a_big ? a_man : b_man;
      y_man      = a_big ? b_man : a_man;
      x_ef       = a_big ? a_ef : b_ef;
      y_ef       = a_big ? b_ef : a_ef;
      d8         = x_ef - y_ef;
      d6         = (d8 > 8'd63) ? 6'd63 : d8[5:0];
      x_al       = {2'b00, x_man, 30'd0};
      y_wide     = {2'b00, y_man, 30'd0, {MW{1'b0}}} >> d6;
      y_al       = y_wide[2*MW-1:MW] | {{(MW-1){1'b0}}, (y_wide[MW-1:0] != '0)};
      eff_sub    = x_sign ^ y_sign;
      add_m      = eff_sub ? x_al - y_al : x_al + y_al;
      add_sign   = ((add_m == '0) && eff_sub) ? 1'b0 : x_sign;

      prod = a_man * b_man;

      q_bit   = (rem_ff >= {1'b0, db_ff});
      rem_sub = q_bit ? rem_ff - {1'b0, db_ff} : rem_ff;

      r_man    = m_ff[MW-1 -: 24];
      r_guard  = m_ff[MW-25];
      r_sticky = (m_ff[MW-26:0] != '0);
      r_inc    = r_guard && (r_sticky || r_man[0]);
      r_sum    = {1'b0, r_man} + {24'd0, r_inc};
      if (r_sum[24]) begin
         r_final = r_sum[24:1];
         r_e     = e_ff + E_ONE;
      end else begin
         r_final = r_sum[23:0];
         r_e     = r_sum[23] ? e_ff : '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      e_in     = e_ff;
      sign_in  = sign_ff;
      res_in   = res_ff;
      da_in    = da_ff;
      db_in    = db_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         rfsc_pkg::FPU_IDLE: begin
            if (fpu_req.start) begin
               case (fpu_req.op)
                  rfsc_pkg::OP_ADD, rfsc_pkg::OP_SUB: begin
                     if (a_nan || b_nan) begin
                        res_in   = rfsc_pkg::CANON_NAN;
                        state_in = rfsc_pkg::FPU_DONE;
                     end else if (a_inf && b_inf) begin
                        res_in   = (a[31] != b_sign_eff) ? rfsc_pkg::CANON_NAN :
                                   {a[31], 8'hFF, 23'd0};
                        state_in = rfsc_pkg::FPU_DONE;
                     end else if (a_inf || b_inf) begin
                        res_in   = {(a_inf ? a[31] : b_sign_eff), 8'hFF, 23'd0};
                        state_in = rfsc_pkg::FPU_DONE;
                     end else begin
                        m_in     = add_m;
                        e_in     = {{(EW-8){1'b0}}, x_ef} + EW'(2);
                        sign_in  = add_sign;
                        state_in = rfsc_pkg::FPU_NORM;
                     end
                  end
                  rfsc_pkg::OP_MUL: begin
                     if (a_nan || b_nan) begin
                        res_in   = rfsc_pkg::CANON_NAN;
                        state_in = rfsc_pkg::FPU_DONE;
                     end else if (a_inf || b_inf) begin
                        res_in   = (a_zero || b_zero) ? rfsc_pkg::CANON_NAN :
                                   {a[31] ^ b[31], 8'hFF, 23'd0};
                        state_in = rfsc_pkg::FPU_DONE;
                     end else begin
                        m_in     = {prod, 8'd0};
                        e_in     = a_e + b_e - EW'(126);
                        sign_in  = a[31] ^ b[31];
                        state_in = rfsc_pkg::FPU_NORM;
                     end
                  end
                  rfsc_pkg::OP_DIV: begin
                     if (a_nan || b_nan || (a_inf && b_inf)) begin
                        res_in   = rfsc_pkg::CANON_NAN;
                        state_in = rfsc_pkg::FPU_DONE;
                     end else if (a_inf) begin
                        res_in   = {a[31] ^ b[31], 8'hFF, 23'd0};
                        state_in = rfsc_pkg::FPU_DONE;
                     end else if (b_zero) begin
                        res_in   = a_zero ? rfsc_pkg::CANON_NAN :
                                   {a[31] ^ b[31], 8'hFF, 23'd0};
                        state_in = rfsc_pkg::FPU_DONE;
                     end else if (b_inf || a_zero) begin
                        res_in   = {a[31] ^ b[31], 31'd0};
                        state_in = rfsc_pkg::FPU_DONE;
                     end else begin
                        da_in    = a_man;
                        db_in    = b_man;
                        e_in     = a_e - b_e + EW'(128);
                        sign_in  = a[31] ^ b[31];
                        state_in = rfsc_pkg::FPU_PRENORM;
                     end
                  end
                  default: state_in = rfsc_pkg::FPU_IDLE;
               endcase
            end
         end
         rfsc_pkg::FPU_PRENORM: begin
            // Bring subnormal operands up to a leading one, one bit a cycle each.
            if (da_ff[23] && db_ff[23]) begin
               rem_in   = {1'b0, da_ff};
               q_in     = '0;
               cnt_in   = 5'd26;
               state_in = rfsc_pkg::FPU_DIVIDE;
            end else begin
               if (!da_ff[23]) begin
                  da_in = {da_ff[22:0], 1'b0};
               end
               if (!db_ff[23]) begin
                  db_in = {db_ff[22:0], 1'b0};
               end
               e_in = e_ff - EW'(!da_ff[23]) + EW'(!db_ff[23]);
            end
         end
         rfsc_pkg::FPU_DIVIDE: begin
            // Restoring division, one quotient bit per cycle.
            q_in   = {q_ff[25:0], q_bit};
            rem_in = {rem_sub[23:0], 1'b0};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               m_in     = {1'b0, q_ff[25:0], q_bit, 28'd0} |
                          {{(MW-1){1'b0}}, (rem_sub != '0)};
               state_in = rfsc_pkg::FPU_NORM;
            end
         end
         rfsc_pkg::FPU_NORM: begin
            if (m_ff == '0) begin
               res_in   = {sign_ff, 31'd0};
               state_in = rfsc_pkg::FPU_DONE;
            end else if (e_ff < E_TINY) begin
               // Far below the subnormal range only the sticky bit survives.
               m_in = {{(MW-1){1'b0}}, 1'b1};
               e_in = E_ONE;
            end else if (e_ff < E_ONE) begin
               m_in = {1'b0, m_ff[MW-1:1]} | {{(MW-1){1'b0}}, m_ff[0]};
               e_in = e_ff + E_ONE;
            end else if (!m_ff[MW-1] && (e_ff > E_ONE)) begin
               m_in = {m_ff[MW-2:0], 1'b0};
               e_in = e_ff - E_ONE;
            end else begin
               state_in = rfsc_pkg::FPU_ROUND;
            end
         end
         rfsc_pkg::FPU_ROUND: begin
            if (r_e >= E_INF) begin
               res_in = {sign_ff, 8'hFF, 23'd0};
            end else begin
               res_in = {sign_ff, r_e[7:0], r_final[22:0]};
            end
            state_in = rfsc_pkg::FPU_DONE;
         end
         rfsc_pkg::FPU_DONE: begin
            state_in = rfsc_pkg::FPU_IDLE;
         end
         default: state_in = rfsc_pkg::FPU_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rfsc_pkg::FPU_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      e_ff    <= e_in;
      sign_ff <= sign_in;
      res_ff  <= res_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
   end

   assign fpu_rsp.done  = (state_ff == rfsc_pkg::FPU_DONE);
   assign fpu_rsp.value = res_ff;

endmodule

[rtl/core/rfsc_back.sv]
module rfsc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fe_valid,
   input  rfsc_pkg::item_type    fe_item,
   output logic                  fe_take,
   output rfsc_pkg::fpu_req_type fpu_req,
   input  rfsc_pkg::fpu_rsp_type fpu_rsp,
   output logic                  empty,
   input  logic                  pop,
   output logic                  rsp_ok,
   output logic [31:0]           rsp_result_value
);

   localparam int D = rfsc_pkg::STACK_DEPTH;

   rfsc_pkg::back_state_type    state_ff, state_in;
   logic [31:0]                 stack_ff [D];
   logic [31:0]                 stack_in [D];
   rfsc_pkg::rsp_type           oq_ff [rfsc_pkg::QUEUE_DEPTH];
   logic [rfsc_pkg::QPTR_W-1:0] oq_wr_ff, oq_wr_in;
   logic [rfsc_pkg::QPTR_W-1:0] oq_rd_ff, oq_rd_in;
   logic [rfsc_pkg::QCNT_W-1:0] oq_cnt_ff, oq_cnt_in;
   logic                        oq_full;
   logic                        rsp_wr;
   rfsc_pkg::rsp_type           rsp_new;
   logic                        rsp_rd;

   assign oq_full = (oq_cnt_ff == rfsc_pkg::QCNT_W'(rfsc_pkg::QUEUE_DEPTH));
   assign empty   = (oq_cnt_ff == '0);
   assign rsp_rd  = pop && !empty;
   assign rsp_ok           = oq_ff[oq_rd_ff].ok;
   assign rsp_result_value = oq_ff[oq_rd_ff].value;

   always_comb begin
      state_in      = state_ff;
      stack_in      = stack_ff;
      fe_take       = 1'b0;
      rsp_wr        = 1'b0;
      rsp_new.ok    = 1'b1;
      rsp_new.value = rfsc_pkg::FLOAT_ZERO;
      fpu_req.start = 1'b0;
      fpu_req.op    = fe_item.op;
      fpu_req.lhs   = stack_ff[1];
      fpu_req.rhs   = stack_ff[0];
      case (state_ff)
         rfsc_pkg::BK_IDLE: begin
            // An operation is started only with a free result slot, so it can
            // always deliver when the float unit finishes.
            if (fe_valid && !oq_full) begin
               fe_take = 1'b1;
               rsp_wr  = 1'b1;
               case (fe_item.cmd)
                  rfsc_pkg::CMD_PUSH: begin
                     for (int i = 1; i < D; i++) begin
                        stack_in[i] = stack_ff[i-1];
                     end
                     stack_in[0] = fe_item.value;
                  end
                  rfsc_pkg::CMD_POP: begin
                     for (int i = 0; i < D - 1; i++) begin
                        stack_in[i] = stack_ff[i+1];
                     end
                  end
                  rfsc_pkg::CMD_READ: begin
                     rsp_new.value = stack_ff[0];
                  end
                  rfsc_pkg::CMD_SWAP: begin
                     stack_in[0] = stack_ff[1];
                     stack_in[1] = stack_ff[0];
                  end
                  rfsc_pkg::CMD_ARITH: begin
                     if ((fe_item.op == rfsc_pkg::OP_DIV) && (stack_ff[0][30:0] == 31'd0)) begin
                        rsp_new.ok = 1'b0;
                     end else begin
                        rsp_wr        = 1'b0;
                        fpu_req.start = 1'b1;
                        state_in      = rfsc_pkg::BK_WAIT;
                     end
                  end
                  default: begin
                     rsp_new.ok = 1'b0;
                  end
               endcase
            end
         end
         rfsc_pkg::BK_WAIT: begin
            if (fpu_rsp.done) begin
               // Two pops then a push: the bottom entry fills the vacated places.
               stack_in[0] = fpu_rsp.value;
               for (int i = 1; i < D - 1; i++) begin
                  stack_in[i] = stack_ff[i+1];
               end
               stack_in[D-1] = stack_ff[D-1];
               rsp_wr        = 1'b1;
               rsp_new.value = fpu_rsp.value;
               state_in      = rfsc_pkg::BK_IDLE;
            end
         end
         default: state_in = rfsc_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      oq_wr_in  = rsp_wr ? oq_wr_ff + rfsc_pkg::QPTR_W'(1) : oq_wr_ff;
      oq_rd_in  = rsp_rd ? oq_rd_ff + rfsc_pkg::QPTR_W'(1) : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff;
      if (rsp_wr && !rsp_rd) begin
         oq_cnt_in = oq_cnt_ff + rfsc_pkg::QCNT_W'(1);
      end else if (!rsp_wr && rsp_rd) begin
         oq_cnt_in = oq_cnt_ff - rfsc_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rfsc_pkg::BK_IDLE;
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
         for (int i = 0; i < D; i++) begin
            stack_ff[i] <= rfsc_pkg::FLOAT_ZERO;
         end
      end else begin
         state_ff  <= state_in;
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
         stack_ff  <= stack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_wr) begin
         oq_ff[oq_wr_ff] <= rsp_new;
      end
   end

endmodule

[tb/rpn_float_stack_calculator_checker.sv]
`timescale 1ns / 1ps

module rpn_float_stack_calculator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic [2:0]  req_type,
   input  logic [31:0] req_push_value,
   input  logic [1:0]  req_op_code,
   input  logic        push,
   input  logic        full,
   input  logic        rsp_ok,
   input  logic [31:0] rsp_result_value,
   input  logic        empty,
   input  logic        pop,
   output int          errors,
   output int          pending
);

   logic [31:0]           model_stack [rfsc_pkg::STACK_DEPTH];
   rfsc_pkg::rsp_type     expected_rsps [$];

   assign pending = expected_rsps.size();

   // Widens a single-precision pattern to a double, keeping signed zeros and
   // subnormals exact.
   function automatic real single_to_real(logic [31:0] b);
      logic [63:0] mag_bits;
      real         mag;
      if (b[30:23] == 8'hFF) begin
         if (b[22:0] != 0)
            return $bitstoreal(64'h7FF8_0000_0000_0000);
         return $bitstoreal({b[31], 11'h7FF, 52'd0});
      end
      if (b[30:0] == 0)
         return $bitstoreal({b[31], 63'd0});
      if (b[30:23] == 8'd0) begin
         mag = b[22:0];
         mag = mag * (2.0 ** (-149));
         mag_bits = $realtobits(mag);
         return $bitstoreal({b[31], mag_bits[62:0]});
      end
      return $bitstoreal({b[31], 11'(b[30:23] + 896), b[22:0], 29'd0});
   endfunction

   // Rounds a double to single precision, nearest even, with subnormals.
   // The double result of one single operation rounds to the same value as
   // the exact result would, since 53 >= 2 * 24 + 2.
   function automatic logic [31:0] round_to_single(real r);
      logic [63:0] d, m, kept, rem, half, sum;
      logic        s;
      int          ex, es, sh;
      d  = $realtobits(r);
      s  = d[63];
      ex = d[62:52];
      if (ex == 2047)
         return (d[51:0] != 0) ? rfsc_pkg::CANON_NAN : {s, 8'hFF, 23'd0};
      if (ex == 0)
         return {s, 31'd0};
      es = ex - 1023 + 127;
      if (es >= 255)
         return {s, 8'hFF, 23'd0};
      m  = {11'd0, 1'b1, d[51:0]};
      sh = (es >= 1) ? 29 : 29 + 1 - es;
      if (sh > 54)
         return {s, 31'd0};
      kept = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0]))
         kept = kept + 64'd1;
      // A carry out of the mantissa moves into the exponent by itself.
      sum = ((es >= 1) ? (64'(es - 1) << 23) : 64'd0) + kept;
      if (sum >= (64'd255 << 23))
         return {s, 8'hFF, 23'd0};
      return {s, sum[30:0]};
   endfunction

   function automatic logic [31:0] float_result(rfsc_pkg::op_type op, logic [31:0] lhs,
                                                logic [31:0] rhs);
      real a, b;
      a = single_to_real(lhs);
      b = single_to_real(rhs);
      case (op)
         rfsc_pkg::OP_ADD: return round_to_single(a + b);
         rfsc_pkg::OP_SUB: return round_to_single(a - b);
         rfsc_pkg::OP_MUL: return round_to_single(a * b);
         default:          return round_to_single(a / b);
      endcase
   endfunction

   task automatic stack_shift_down(logic [31:0] v);
      for (int i = rfsc_pkg::STACK_DEPTH - 1; i > 0; i--)
         model_stack[i] = model_stack[i - 1];
      model_stack[0] = v;
   endtask

   task automatic stack_shift_up();
      for (int i = 0; i < rfsc_pkg::STACK_DEPTH - 1; i++)
         model_stack[i] = model_stack[i + 1];
   endtask

   task automatic predict_request(logic [2:0] kind, logic [31:0] value,
                                  rfsc_pkg::op_type op);
      rfsc_pkg::rsp_type r;
      logic [31:0]       t;
      r.ok    = 1'b1;
      r.value = rfsc_pkg::FLOAT_ZERO;
      case (kind)
         rfsc_pkg::REQ_PUSH: stack_shift_down(value);
         rfsc_pkg::REQ_POP:  stack_shift_up();
         rfsc_pkg::REQ_READ: r.value = model_stack[0];
         rfsc_pkg::REQ_SWAP: begin
            t = model_stack[0];
            model_stack[0] = model_stack[1];
            model_stack[1] = t;
         end
         rfsc_pkg::REQ_ARITH: begin
            if (op == rfsc_pkg::OP_DIV && model_stack[0][30:0] == 31'd0) begin
               r.ok = 1'b0;
            end else begin
               r.value = float_result(op, model_stack[1], model_stack[0]);
               stack_shift_up();
               stack_shift_up();
               stack_shift_down(r.value);
            end
         end
         default: r.ok = 1'b0;
      endcase
      expected_rsps.push_back(r);
   endtask

   always @(posedge clock) begin
      rfsc_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < rfsc_pkg::STACK_DEPTH; i++)
            model_stack[i] = rfsc_pkg::FLOAT_ZERO;
         expected_rsps.delete();
         errors = 0;
      end else begin
         if (pop && !empty) begin
            if (expected_rsps.size() == 0) begin
               $error("result item with no expectation waiting");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_ok !== want.ok) begin
                  $error("ok mismatch: expected %0d, actual %0d", want.ok, rsp_ok);
                  errors++;
               end
               if (rsp_result_value !== want.value) begin
                  $error("result_value mismatch: expected %08h, actual %08h",
                         want.value, rsp_result_value);
                  errors++;
               end
            end
         end
         if (push && !full)
            predict_request(req_type, req_push_value, rfsc_pkg::op_type'(req_op_code));
      end
   end

endmodule

[tb/rpn_float_stack_calculator_tb.sv]
`timescale 1ns / 1ps

module rpn_float_stack_calculator_tb;

   localparam logic [2:0] REQ_UNUSED_5 = 3'd5;
   localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
   localparam logic [2:0] REQ_UNUSED_7 = 3'd7;
   localparam int         STALL_LIMIT  = 5000;
   localparam int         HOLD_CYCLES  = 300;

   logic        clock;
   logic        reset;
   logic [2:0]  req_type;
   logic [31:0] req_push_value;
   logic [1:0]  req_op_code;
   logic        push;
   logic        full;
   logic        rsp_ok;
   logic [31:0] rsp_result_value;
   logic        empty;
   logic        pop;
   int          errors;
   int          pending;
   int          send_idle_pct;
   int          recv_stall_pct;
   logic        hold_request;
   int          quiet_cycles;

   rpn_float_stack_calculator u_top (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_push_value   (req_push_value),
      .req_op_code      (req_op_code),
      .push             (push),
      .full             (full),
      .rsp_ok           (rsp_ok),
      .rsp_result_value (rsp_result_value),
      .empty            (empty),
      .pop              (pop)
   );

   rpn_float_stack_calculator_checker u_chk (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_push_value   (req_push_value),
      .req_op_code      (req_op_code),
      .push             (push),
      .full             (full),
      .rsp_ok           (rsp_ok),
      .rsp_result_value (rsp_result_value),
      .empty            (empty),
      .pop              (pop),
      .errors           (errors),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: random stalls, and one long hold-off on request.
   initial begin
      logic hold_taken;
      hold_taken = 1'b0;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            pop = ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("rpn_float_stack_calculator_tb: done, errors");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(logic [2:0] kind, logic [31:0] value,
                               rfsc_pkg::op_type op);
      if ($urandom_range(99) < send_idle_pct) begin
         push = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_type       = kind;
      req_push_value = value;
      req_op_code    = op;
      push           = 1'b1;
      while (full) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_float();
      case ($urandom_range(9))
         0: return {1'($urandom_range(1)), 31'd0};
         1: return {1'($urandom_range(1)), 8'hFF, 23'd0};
         2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
         3: return {1'($urandom_range(1)), 8'd0, 23'($urandom())};
         4: return {1'($urandom_range(1)), 8'($urandom_range(1, 3)), 23'($urandom())};
         5: return {1'($urandom_range(1)), 8'($urandom_range(250, 254)), 23'($urandom())};
         6: return $urandom();
         default: return {1'($urandom_range(1)), 8'($urandom_range(115, 140)),
                          23'($urandom())};
      endcase
   endfunction

   task automatic send_random();
      int dice;
      dice = $urandom_range(99);
      if (dice < 30)
         send_request(rfsc_pkg::REQ_PUSH, pick_float(),
                      rfsc_pkg::op_type'($urandom_range(3)));
      else if (dice < 65)
         send_request(rfsc_pkg::REQ_ARITH, $urandom(), rfsc_pkg::op_type'($urandom_range(3)));
      else if (dice < 80)
         send_request(rfsc_pkg::REQ_READ, $urandom(), rfsc_pkg::op_type'($urandom_range(3)));
      else if (dice < 88)
         send_request(rfsc_pkg::REQ_POP, $urandom(), rfsc_pkg::op_type'($urandom_range(3)));
      else if (dice < 96)
         send_request(rfsc_pkg::REQ_SWAP, $urandom(), rfsc_pkg::op_type'($urandom_range(3)));
      else
         send_request(3'($urandom_range(5, 7)), $urandom(),
                      rfsc_pkg::op_type'($urandom_range(3)));
   endtask

   initial begin
      reset          = 1'b1;
      push           = 1'b0;
      req_type       = rfsc_pkg::REQ_PUSH;
      req_push_value = 32'd0;
      req_op_code    = rfsc_pkg::OP_ADD;
      hold_request   = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // Directed: reset contents, extremes, every operation, special cases.
      send_request(rfsc_pkg::REQ_READ, 32'd0, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_ARITH, 32'd0, rfsc_pkg::OP_DIV);
      send_request(rfsc_pkg::REQ_PUSH, 32'hFFFF_FFFF, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_READ, 32'd0, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_PUSH, 32'h3F80_0000, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_PUSH, 32'h8000_0000, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_ARITH, 32'd0, rfsc_pkg::OP_DIV);
      send_request(rfsc_pkg::REQ_SWAP, 32'd0, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_READ, 32'd0, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_ARITH, 32'd0, rfsc_pkg::OP_DIV);
      send_request(rfsc_pkg::REQ_ARITH, 32'd0, rfsc_pkg::OP_DIV);
      send_request(rfsc_pkg::REQ_PUSH, 32'h0000_0001, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_PUSH, 32'h807F_FFFF, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_ARITH, 32'd0, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_PUSH, 32'h7F7F_FFFF, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_PUSH, 32'h7F7F_FFFF, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_ARITH, 32'd0, rfsc_pkg::OP_MUL);
      send_request(rfsc_pkg::REQ_PUSH, 32'h7F80_0000, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_ARITH, 32'd0, rfsc_pkg::OP_SUB);
      send_request(rfsc_pkg::REQ_POP, 32'd0, rfsc_pkg::OP_ADD);
      send_request(REQ_UNUSED_5, 32'd0, rfsc_pkg::OP_ADD);
      send_request(REQ_UNUSED_6, 32'd0, rfsc_pkg::OP_SUB);
      send_request(REQ_UNUSED_7, 32'd0, rfsc_pkg::OP_MUL);
      send_request(rfsc_pkg::REQ_PUSH, 32'h8000_0000, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_PUSH, 32'h8000_0000, rfsc_pkg::OP_ADD);
      send_request(rfsc_pkg::REQ_ARITH, 32'd0, rfsc_pkg::OP_ADD);

      // Random phases with different idle patterns on each side.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 7; recv_stall_pct = 7; end
         endcase
         for (int n = 0; n < 320; n++)
            send_random();
         if (phase == 1) begin
            // The block has to fill up and stall its input during the hold-off.
            hold_request = 1'b1;
            for (int n = 0; n < 20; n++)
               send_random();
            push = 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
      end

      push = 1'b0;
      wait (pending == 0);
      repeat (100) @(negedge clock);
      if (errors == 0)
         $display("rpn_float_stack_calculator_tb: done, clean");
      else
         $display("rpn_float_stack_calculator_tb: done, errors");
      $finish;
   end

endmodule

[rpn_float_stack_calculator.f]
rtl/core/rfsc_pkg.sv
rtl/core/rfsc_front.sv
rtl/core/rfsc_fpu.sv
rtl/core/rfsc_back.sv
rtl/core/rpn_float_stack_calculator.sv
tb/rpn_float_stack_calculator_checker.sv
tb/rpn_float_stack_calculator_tb.sv
